/* rtl/core/utf8sdc_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, result kind codes and the classification range tables.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sdc_pkg;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]  kind;
      logic [20:0] codepoint;
      logic [15:0] char_index;
      logic [2:0]  seq_length;
      logic        string_valid;
      logic [15:0] byte_total;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      is_alpha;
      logic      is_digit;
   } result_type;

   typedef struct packed {
      logic [20:0] lo;
      logic [20:0] hi;
   } span_type;

   localparam int ALPHA_COUNT = 21;
   localparam int DIGIT_COUNT = 11;

   localparam span_type ALPHA_SPANS [ALPHA_COUNT] = '{
      '{21'h00041, 21'h0005A}, '{21'h00061, 21'h0007A}, '{21'h000C0, 21'h000D6},
      '{21'h000D8, 21'h000F6}, '{21'h000F8, 21'h000FF}, '{21'h00100, 21'h0017F},
      '{21'h00370, 21'h003FF}, '{21'h00400, 21'h004FF}, '{21'h00531, 21'h0058F},
      '{21'h00590, 21'h005FF}, '{21'h00600, 21'h006FF}, '{21'h00700, 21'h0074F},
      '{21'h00780, 21'h007BF}, '{21'h00900, 21'h0097F}, '{21'h00981, 21'h009FF},
      '{21'h00A00, 21'h00A7F}, '{21'h00A80, 21'h00AFF}, '{21'h00B00, 21'h00B7F},
      '{21'h00B81, 21'h00BFF}, '{21'h00C00, 21'h00C7F}, '{21'h00C80, 21'h00CFF}
   };

   localparam span_type DIGIT_SPANS [DIGIT_COUNT] = '{
      '{21'h00030, 21'h00039}, '{21'h00660, 21'h00669}, '{21'h006F0, 21'h006F9},
      '{21'h00966, 21'h0096F}, '{21'h009E6, 21'h009EF}, '{21'h00A66, 21'h00A6F},
      '{21'h00AE6, 21'h00AEF}, '{21'h00B66, 21'h00B6F}, '{21'h00BE6, 21'h00BEF},
      '{21'h00C66, 21'h00C6F}, '{21'h0FF10, 21'h0FF19}
   };

endpackage

`default_nettype wire

/* rtl/core/utf8sdc_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks sequence state and counters, and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sdc_front #(
   parameter int COUNT_BITS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  wire [7:0]               text_byte,
   output logic                    push,
   output utf8sdc_pkg::entry_type  push_entry
);
   import utf8sdc_pkg::*;

   logic [1:0]            pending_ff, pending_in;
   logic [2:0]            size_ff, size_in;
   logic [20:0]           partial_ff, partial_in;
   logic [COUNT_BITS-1:0] char_count_ff, char_count_in;
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic                  error_ff, error_in;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] clamp16(input logic [COUNT_BITS-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   logic        finish;
   logic [2:0]  fin_size;
   logic [20:0] fin_cp;
   logic [20:0] shifted;

   always_comb begin
      pending_in    = pending_ff;
      size_in       = size_ff;
      partial_in    = partial_ff;
      char_count_in = char_count_ff;
      byte_count_in = byte_count_ff;
      error_in      = error_ff;
      push          = 1'b0;
      push_entry    = '0;
      finish        = 1'b0;
      fin_size      = size_ff;
      fin_cp        = '0;
      shifted       = {partial_ff[14:0], text_byte[5:0]};
      if (accept) begin
         if (text_byte == 8'h00) begin
            push                    = 1'b1;
            push_entry.kind         = KIND_END;
            push_entry.char_index   = clamp16(char_count_ff);
            push_entry.string_valid = !error_ff && (pending_ff == 2'd0);
            push_entry.byte_total   = clamp16(byte_count_ff);
            pending_in    = '0;
            size_in       = '0;
            partial_in    = '0;
            char_count_in = '0;
            byte_count_in = '0;
            error_in      = 1'b0;
         end else begin
            byte_count_in = sat_inc(byte_count_ff);
            priority if (pending_ff != 2'd0) begin
               pending_in = pending_ff - 2'd1;
               if (pending_ff == 2'd1) begin
                  finish   = 1'b1;
                  fin_size = size_ff;
                  fin_cp   = shifted;
               end else begin
                  partial_in = shifted;
               end
            end else if (!text_byte[7]) begin
               finish   = 1'b1;
               fin_size = 3'd1;
               fin_cp   = {13'd0, text_byte};
            end else if (text_byte[7:5] == 3'b110) begin
               size_in    = 3'd2;
               pending_in = 2'd1;
               partial_in = {16'd0, text_byte[4:0]};
            end else if (text_byte[7:4] == 4'b1110) begin
               size_in    = 3'd3;
               pending_in = 2'd2;
               partial_in = {17'd0, text_byte[3:0]};
            end else if (text_byte[7:3] == 5'b11110) begin
               size_in    = 3'd4;
               pending_in = 2'd3;
               partial_in = {18'd0, text_byte[2:0]};
            end else begin
               if (!error_ff) begin
                  push                  = 1'b1;
                  push_entry.kind       = KIND_ERROR;
                  push_entry.char_index = clamp16(char_count_ff);
                  push_entry.seq_length = 3'd1;
               end
               error_in      = 1'b1;
               size_in       = '0;
               partial_in    = '0;
               char_count_in = sat_inc(char_count_ff);
            end
            if (finish) begin
               if (!error_ff) begin
                  push                  = 1'b1;
                  push_entry.kind       = KIND_CHAR;
                  push_entry.codepoint  = fin_cp;
                  push_entry.char_index = clamp16(char_count_ff);
                  push_entry.seq_length = fin_size;
               end
               char_count_in = sat_inc(char_count_ff);
               size_in       = '0;
               partial_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         size_ff       <= '0;
         partial_ff    <= '0;
         char_count_ff <= '0;
         byte_count_ff <= '0;
         error_ff      <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         size_ff       <= size_in;
         partial_ff    <= partial_in;
         char_count_ff <= char_count_in;
         byte_count_ff <= byte_count_in;
         error_ff      <= error_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/utf8sdc_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sdc_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  utf8sdc_pkg::entry_type  push_entry,
   output logic                    full,
   output logic                    head_valid,
   output utf8sdc_pkg::entry_type  head_entry,
   input  wire                     pop
);
   import utf8sdc_pkg::*;

   entry_type           mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign full       = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/utf8sdc_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Classifies queued codepoints against the range tables and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sdc_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     head_valid,
   input  utf8sdc_pkg::entry_type  head_entry,
   output logic                    pop,
   output logic                    out_valid,
   output utf8sdc_pkg::result_type out_result,
   input  wire                     out_ready
);
   import utf8sdc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   logic       alpha_hit, digit_hit;

   always_comb begin
      alpha_hit = 1'b0;
      digit_hit = 1'b0;
      for (int i = 0; i < ALPHA_COUNT; i++) begin
         if (head_entry.codepoint >= ALPHA_SPANS[i].lo &&
             head_entry.codepoint <= ALPHA_SPANS[i].hi) begin
            alpha_hit = 1'b1;
         end
      end
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (head_entry.codepoint >= DIGIT_SPANS[i].lo &&
             head_entry.codepoint <= DIGIT_SPANS[i].hi) begin
            digit_hit = 1'b1;
         end
      end
   end

   assign pop = head_valid && (!out_valid_ff || out_ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff.entry    <= head_entry;
         result_ff.is_alpha <= alpha_hit && (head_entry.kind == KIND_CHAR);
         result_ff.is_digit <= digit_hit && (head_entry.kind == KIND_CHAR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

/* rtl/core/utf8_stream_decoder_classifier.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder and classifier
// Decodes a NUL-terminated UTF-8 byte stream into character, error and end
// results with alphabetic and digit classification.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while req_tready is high and gives at
// most one result per byte. The front end updates the sequence state as each
// byte is accepted, so a new byte is accepted on every cycle while the
// four-entry queue has room. A result passes from its completing byte into
// the queue and then through the classification into the output register.
`default_nettype none

module utf8_stream_decoder_classifier #(
   parameter int COUNT_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // text_byte[7:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // codepoint[20:0], char_index[36:21], seq_length[39:37], is_alpha[40],
   // is_digit[41], string_valid[42], byte_total[58:43], zero fill[63:59]
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser    // kind[1:0]
);
   import utf8sdc_pkg::*;

   logic       accept;
   logic       push;
   entry_type  push_entry;
   logic       full;
   logic       head_valid;
   entry_type  head_entry;
   logic       pop;
   result_type out_result;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   utf8sdc_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_tdata),
      .push       (push),
      .push_entry (push_entry)
   );

   utf8sdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   utf8sdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_result (out_result),
      .out_ready  (rsp_tready)
   );

   assign rsp_tuser = out_result.entry.kind;
   assign rsp_tdata = {5'd0,
                       out_result.entry.byte_total,
                       out_result.entry.string_valid,
                       out_result.is_digit,
                       out_result.is_alpha,
                       out_result.entry.seq_length,
                       out_result.entry.char_index,
                       out_result.entry.codepoint};

endmodule

`default_nettype wire
